@@ rtl/core/mtep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the MIDI track event parser
// Byte and result transfer types, parse phases, result kinds and the status
// and meta type codes that the decoder recognizes.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned ValueW = 28;
  localparam int unsigned CountW = 32;
  localparam int unsigned TempoW = 24;

  // status and meta codes
  localparam logic [7:0] StatusMeta   = 8'hFF;
  localparam logic [3:0] HiSysCommon  = 4'hF;
  localparam logic [3:0] HiProgChange = 4'hC;
  localparam logic [3:0] HiChanPress  = 4'hD;
  localparam logic [3:0] HiNoteOn     = 4'h9;
  localparam logic [3:0] LoSysex      = 4'h0;
  localparam logic [3:0] LoTimeCode   = 4'h1;
  localparam logic [3:0] LoSongPos    = 4'h2;
  localparam logic [3:0] LoSongSel    = 4'h3;

  localparam logic [7:0] MetaSeqNum   = 8'h00;
  localparam logic [7:0] MetaChanPfx  = 8'h20;
  localparam logic [7:0] MetaPort     = 8'h21;
  localparam logic [7:0] MetaEndTrack = 8'h2F;
  localparam logic [7:0] MetaTempo    = 8'h51;
  localparam logic [7:0] MetaSmpte    = 8'h54;
  localparam logic [7:0] MetaTimeSig  = 8'h58;
  localparam logic [7:0] MetaKeySig   = 8'h59;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_META_TYPE = 4'd2,
    PH_META_LEN  = 4'd3,
    PH_TEMPO     = 4'd4,
    PH_SYSEX_LEN = 4'd5,
    PH_SKIP      = 4'd6,
    PH_DATA1     = 4'd7,
    PH_DATA2     = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DELTA = 3'd0,
    KIND_CHAN  = 3'd1,
    KIND_TEMPO = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  note_on_count;
  } out_item_t;

endpackage

@@ rtl/core/midi_track_event_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser: byte-wise standard MIDI file track event decoder
// Walks the bytes of a track chunk, decoding delta times, running status,
// channel messages, tempo and end of track, and skipping other events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one track byte per transfer (in_valid_i / in_stall_o),
//   with track_start set on the first byte of a new track to clear the
//   parse phase, running status and end flag.
//   Output channel: at most one result per byte (out_valid_o / out_stall_i):
//   delta ticks, packed channel message, tempo, end of track or error,
//   each carrying the running note-on count.
//   A result is registered and appears in the cycle after the byte that caused it.
//   Throughput: one byte per cycle unless the input is stalled; the whole decode
//   of a byte sits between the parser state registers and the result register.
//   The input is stalled only while a result is held in the result register
//   and the receiver stalls; bytes that give no result still need that
//   register free. When the receiver stalls, the held result does not change.
//   Reset: parser expects a delta time, running status and note count are
//   cleared, no result is pending.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mtep_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mtep_pkg::out_item_t  out_data_o
);
  import mtep_pkg::*;

  // parser state
  phase_e              phase_q, phase_d;
  logic [7:0]          rs_q, rs_d;
  logic                seen_q, seen_d;
  logic [ValueW-1:0]   vlq_q, vlq_d;
  logic [1:0]          bytes_q, bytes_d;
  logic [ValueW-1:0]   rem_q, rem_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          meta_q, meta_d;
  logic [TempoW-1:0]   tempo_q, tempo_d;
  logic                ended_q, ended_d;
  logic [CountW-1:0]   notes_q, notes_d;

  // result register
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic                in_fire;
  logic [7:0]          b;

  // state after an optional track restart
  phase_e              ph_pre;
  logic [7:0]          rs_pre;
  logic                seen_pre;
  logic [ValueW-1:0]   vlq_pre;
  logic [1:0]          bytes_pre;
  logic [ValueW-1:0]   rem_pre;
  logic [TempoW-1:0]   tempo_pre;
  logic                ended_pre;

  // shared decode terms
  logic [ValueW-1:0]   vlq_shift;
  logic                vlq_more;
  logic                vlq_long;
  logic [3:0]          rs_hi;
  logic                rs_chan;
  logic                rs_one_data;
  logic [3:0]          b_hi;
  logic                b_chan;

  logic                emit;
  kind_e               emit_kind;
  logic [ValueW-1:0]   emit_value;

  assign b          = in_data_i.data_byte;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // track restart clears the per-track state
  always_comb begin
    if (in_data_i.track_start) begin
      ph_pre    = PH_DELTA;
      rs_pre    = '0;
      seen_pre  = 1'b0;
      vlq_pre   = '0;
      bytes_pre = '0;
      rem_pre   = '0;
      tempo_pre = '0;
      ended_pre = 1'b0;
    end else begin
      ph_pre    = phase_q;
      rs_pre    = rs_q;
      seen_pre  = seen_q;
      vlq_pre   = vlq_q;
      bytes_pre = bytes_q;
      rem_pre   = rem_q;
      tempo_pre = tempo_q;
      ended_pre = ended_q;
    end
  end

  assign vlq_shift   = {vlq_pre[ValueW-8:0], b[6:0]};
  assign vlq_more    = b[7];
  assign vlq_long    = b[7] && (bytes_pre == 2'd3);
  assign rs_hi       = rs_pre[7:4];
  assign rs_chan     = rs_pre[7] && (rs_hi != HiSysCommon);
  assign rs_one_data = (rs_hi == HiProgChange) || (rs_hi == HiChanPress);
  assign b_hi        = b[7:4];
  assign b_chan      = b[7] && (b_hi != HiSysCommon);

  // next state
  always_comb begin
    phase_d = ph_pre;
    rs_d    = rs_pre;
    seen_d  = seen_pre;
    vlq_d   = vlq_pre;
    bytes_d = bytes_pre;
    rem_d   = rem_pre;
    tempo_d = tempo_pre;
    ended_d = ended_pre;
    first_d = first_q;
    meta_d  = meta_q;
    notes_d = notes_q;
    if (!ended_pre) begin
      unique case (ph_pre)
        PH_DELTA: begin
          if (vlq_long) begin
            vlq_d   = '0;
            bytes_d = '0;
          end else if (vlq_more) begin
            vlq_d   = vlq_shift;
            bytes_d = bytes_pre + 2'd1;
          end else begin
            vlq_d   = '0;
            bytes_d = '0;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          vlq_d   = '0;
          bytes_d = '0;
          if (b[7]) begin
            // new status byte
            rs_d   = b;
            seen_d = 1'b1;
            if (b == StatusMeta) begin
              phase_d = PH_META_TYPE;
            end else if (b_chan) begin
              phase_d = PH_DATA1;
            end else begin
              case (b[3:0])
                LoSysex: phase_d = PH_SYSEX_LEN;
                LoTimeCode, LoSongSel: begin
                  rem_d   = ValueW'(1);
                  phase_d = PH_SKIP;
                end
                LoSongPos: begin
                  rem_d   = ValueW'(2);
                  phase_d = PH_SKIP;
                end
                default: phase_d = PH_DELTA;
              endcase
            end
          end else if (!seen_pre) begin
            phase_d = PH_DELTA;
          end else if (rs_pre == StatusMeta) begin
            // running status: byte is the first one after the status
            meta_d  = b;
            phase_d = PH_META_LEN;
          end else if (rs_chan) begin
            if (rs_one_data) begin
              phase_d = PH_DELTA;
            end else begin
              first_d = b;
              phase_d = PH_DATA2;
            end
          end else begin
            case (rs_pre[3:0])
              LoSysex: begin
                rem_d   = {{(ValueW-7){1'b0}}, b[6:0]};
                phase_d = (b[6:0] == 7'd0) ? PH_DELTA : PH_SKIP;
              end
              LoTimeCode, LoSongSel: begin
                rem_d   = '0;
                phase_d = PH_DELTA;
              end
              LoSongPos: begin
                rem_d   = ValueW'(1);
                phase_d = PH_SKIP;
              end
              default: phase_d = PH_STATUS;
            endcase
          end
        end
        PH_META_TYPE: begin
          meta_d  = b;
          vlq_d   = '0;
          bytes_d = '0;
          phase_d = PH_META_LEN;
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          if (vlq_long) begin
            vlq_d   = '0;
            bytes_d = '0;
            phase_d = PH_DELTA;
          end else if (vlq_more) begin
            vlq_d   = vlq_shift;
            bytes_d = bytes_pre + 2'd1;
          end else begin
            vlq_d   = '0;
            bytes_d = '0;
            phase_d = PH_SKIP;
            if (ph_pre == PH_SYSEX_LEN) begin
              rem_d = vlq_shift;
            end else begin
              case (meta_q)
                MetaSeqNum, MetaKeySig:  rem_d = ValueW'(2);
                MetaChanPfx, MetaPort:   rem_d = ValueW'(1);
                MetaSmpte:               rem_d = ValueW'(5);
                MetaTimeSig:             rem_d = ValueW'(4);
                MetaEndTrack: begin
                  ended_d = 1'b1;
                  phase_d = PH_DELTA;
                end
                MetaTempo: begin
                  tempo_d = '0;
                  rem_d   = ValueW'(3);
                  phase_d = PH_TEMPO;
                end
                default:                 rem_d = vlq_shift;
              endcase
            end
            // zero-length skip goes straight back to delta time
            if (phase_d == PH_SKIP && rem_d == '0) begin
              phase_d = PH_DELTA;
            end
          end
        end
        PH_TEMPO: begin
          tempo_d = {tempo_pre[TempoW-9:0], b};
          rem_d   = rem_pre - ValueW'(1);
          if (rem_pre == ValueW'(1)) begin
            phase_d = PH_DELTA;
          end
        end
        PH_SKIP: begin
          rem_d = rem_pre - ValueW'(1);
          if (rem_pre == ValueW'(1)) begin
            phase_d = PH_DELTA;
          end
        end
        PH_DATA1: begin
          if (rs_one_data) begin
            phase_d = PH_DELTA;
          end else begin
            first_d = b;
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          phase_d = PH_DELTA;
          if (rs_hi == HiNoteOn) begin
            notes_d = notes_q + CountW'(1);
          end
        end
        default: begin
          phase_d = PH_DELTA;
          vlq_d   = '0;
          bytes_d = '0;
        end
      endcase
    end
  end

  // result of this byte
  always_comb begin
    emit       = 1'b0;
    emit_kind  = KIND_DELTA;
    emit_value = '0;
    if (!ended_pre) begin
      unique case (ph_pre)
        PH_DELTA: begin
          if (vlq_long) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end else if (!vlq_more) begin
            emit       = 1'b1;
            emit_kind  = KIND_DELTA;
            emit_value = vlq_shift;
          end
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (!seen_pre) begin
              emit      = 1'b1;
              emit_kind = KIND_ERROR;
            end else if (rs_chan) begin
              if (rs_one_data) begin
                emit       = 1'b1;
                emit_kind  = KIND_CHAN;
                emit_value = {{(ValueW-16){1'b0}}, b, rs_pre};
              end
            end else if (rs_pre != StatusMeta) begin
              case (rs_pre[3:0])
                LoSysex, LoTimeCode, LoSongPos, LoSongSel: emit = 1'b0;
                default: begin
                  // system message without data: byte is reported as a one-byte delta time
                  emit       = 1'b1;
                  emit_kind  = KIND_DELTA;
                  emit_value = {{(ValueW-8){1'b0}}, b};
                end
              endcase
            end
          end
        end
        PH_META_LEN: begin
          if (vlq_long) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end else if (!vlq_more && meta_q == MetaEndTrack) begin
            emit      = 1'b1;
            emit_kind = KIND_END;
          end
        end
        PH_SYSEX_LEN: begin
          if (vlq_long) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end
        end
        PH_TEMPO: begin
          if (rem_pre == ValueW'(1)) begin
            emit       = 1'b1;
            emit_kind  = KIND_TEMPO;
            emit_value = {{(ValueW-TempoW){1'b0}}, tempo_pre[TempoW-9:0], b};
          end
        end
        PH_DATA1: begin
          if (rs_one_data) begin
            emit       = 1'b1;
            emit_kind  = KIND_CHAN;
            emit_value = {{(ValueW-16){1'b0}}, b, rs_pre};
          end
        end
        PH_DATA2: begin
          emit       = 1'b1;
          emit_kind  = KIND_CHAN;
          emit_value = {{(ValueW-24){1'b0}}, b, first_q, rs_pre};
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // result register: loads on a transfer that gives a result
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = in_fire && emit;
      if (in_fire && emit) begin
        out_data_d.kind          = emit_kind;
        out_data_d.value         = emit_value;
        out_data_d.note_on_count = notes_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DELTA;
      rs_q        <= '0;
      seen_q      <= 1'b0;
      vlq_q       <= '0;
      bytes_q     <= '0;
      rem_q       <= '0;
      first_q     <= '0;
      meta_q      <= '0;
      tempo_q     <= '0;
      ended_q     <= 1'b0;
      notes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        rs_q    <= rs_d;
        seen_q  <= seen_d;
        vlq_q   <= vlq_d;
        bytes_q <= bytes_d;
        rem_q   <= rem_d;
        first_q <= first_d;
        meta_q  <= meta_d;
        tempo_q <= tempo_d;
        ended_q <= ended_d;
        notes_q <= notes_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a transfer that gives a result always shows it next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit |=> out_valid_o)
    else $error("result of an accepted byte was dropped");

  // skipping always has bytes left to skip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> rem_q != '0)
    else $error("skip phase with zero count");

  // a remembered running status is a real status byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> rs_q[7])
    else $error("running status without its status bit");

  // after end of track, bytes leave the parser untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ended_q && !in_data_i.track_start |=>
      $stable(notes_q) && $stable(phase_q) && ended_q)
    else $error("parser state moved after end of track");

endmodule
